/* hdl/dsdft_pkg.sv */
// Shared types, constants and the twiddle generator for the damped sliding DFT.
// Used by the controller, the datapath and the top level; depends on nothing.
package dsdft_pkg;

    localparam int IDX_W      = 6;
    localparam int X_W        = 17;
    localparam int TW_W       = 18;
    localparam int DAMP_W     = 17;
    localparam int CORDIC_N   = 30;
    localparam logic [DAMP_W-1:0] DAMP_ONE = 17'd65536;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam longint TURN_ATAN [CORDIC_N] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    typedef struct packed {
        logic        op;
        logic [15:0] sample;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic [31:0]      bin_real;
        logic [31:0]      bin_imag;
        logic             last_bin;
        logic [IDX_W-1:0] peak_index;
    } out_t;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic             hist_rd;
        logic             make_diff;
        logic             issue;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic busy;
    } sts_t;

    // Rotates gain-corrected unity to the given phase (fraction of a turn in 32 bits)
    // and returns {cos, sin} in Q16. Only evaluated on constants.
    function automatic logic [2*TW_W-1:0] twiddle(input logic [31:0] phase);
        logic [31:0] p;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        p    = phase;
        flip = 1'b0;
        x    = 652032874;
        y    = 0;
        if (p >= 32'h4000_0000 && p < 32'hC000_0000)
        begin
            p    = p - 32'h8000_0000;
            flip = 1'b1;
        end
        z = p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
        for (int i = 0; i < CORDIC_N; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - TURN_ATAN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + TURN_ATAN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        return {c[TW_W-1:0], s[TW_W-1:0]};
    endfunction

endpackage

/* hdl/dsdft_ctrl.sv */
// Sequencer for the damped sliding DFT: request handshake, history step and bin issue.
// Depends on dsdft_pkg; drives dsdft_dp through a command struct.
module dsdft_ctrl #(
    parameter int WINDOW = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  dsdft_pkg::sts_t  sts,
    output dsdft_pkg::cmd_t  cmd
);

    localparam int KW = $clog2(WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HIST  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] slot_reg, slot_next;
    logic          accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.slot   = dsdft_pkg::IDX_W'(slot_reg);
        cmd.k      = dsdft_pkg::IDX_W'(k_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == dsdft_pkg::OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                        slot_next = '0;
                    end
                    else
                    begin
                        cmd.load    = 1'b1;
                        cmd.hist_rd = 1'b1;
                        state_next  = ST_HIST;
                    end
                end
            end
            ST_HIST:
            begin
                // The oldest sample is out of the history now; replace it.
                cmd.make_diff = 1'b1;
                slot_next     = (slot_reg == KW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                k_next        = '0;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (sts.adv)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg == KW'(WINDOW - 1))
                    begin
                        k_next     = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Wait for every bin write-back before the next request may read.
                if (!sts.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

/* hdl/dsdft_dp.sv */
// Datapath of the damped sliding DFT: bin and history memories, shared complex
// multiply pipeline, peak search and output register. Depends on dsdft_pkg.
module dsdft_dp #(
    parameter int WINDOW      = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dsdft_pkg::cmd_t                    cmd,
    output dsdft_pkg::sts_t                    sts,
    input  logic [15:0]                        sample,
    input  logic [dsdft_pkg::DAMP_W-1:0]       damping,
    output logic                               out_valid,
    input  logic                               out_ready,
    output dsdft_pkg::out_t                    out_data
);

    localparam int KW     = $clog2(WINDOW);
    localparam int XW     = dsdft_pkg::X_W;
    localparam int TWW    = dsdft_pkg::TW_W;
    localparam int SB_TOP = (SAMPLE_BITS <= 16) ? SAMPLE_BITS - 1 : 0;

    // Twiddle table, one entry per bin, built at elaboration.
    logic [2*TWW-1:0] tw_tab [WINDOW];
    for (genvar g = 0; g < WINDOW; g++)
    begin : g_tw
        localparam logic [31:0] PH = 32'((64'(g) << 32) / WINDOW);
        assign tw_tab[g] = dsdft_pkg::twiddle(PH);
    end

    logic               adv;
    logic [KW-1:0]      k_in;
    logic [KW-1:0]      slot_in;

    // Sample extension to the working width.
    logic [XW-1:0]      x_ext;
    logic               x_sign;
    assign x_sign = (SAMPLE_BITS <= 16) ? sample[SB_TOP] : 1'b0;
    always_comb
    begin
        for (int i = 0; i < XW; i++)
        begin
            if (i < SAMPLE_BITS && i < 16)
                x_ext[i] = sample[i];
            else if (i < SAMPLE_BITS)
                x_ext[i] = 1'b0;
            else
                x_ext[i] = x_sign;
        end
    end

    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] hist_q;
    logic                 hist_vld_q;
    logic signed [25:0]   diff_reg;
    logic signed [XW:0]   delta;
    logic [XW-1:0]        hist_mem [WINDOW];
    logic [WINDOW-1:0]    hist_vld_reg;
    logic [31:0]          re_mem [WINDOW];
    logic [31:0]          im_mem [WINDOW];
    logic [WINDOW-1:0]    bin_vld_reg;

    assign k_in    = cmd.k[KW-1:0];
    assign slot_in = cmd.slot[KW-1:0];
    assign delta   = $signed({x_reg[XW-1], x_reg})
                   - $signed({hist_q[XW-1] & hist_vld_q, hist_q & {XW{hist_vld_q}}});

    // Pipeline registers.
    logic                   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [KW-1:0]          k0_reg, k1_reg, k2_reg, k3_reg, k4_reg;
    logic [31:0]            re_q, im_q;
    logic                   bvld_q;
    logic signed [TWW-1:0]  twc0_reg, tws0_reg;
    logic signed [TWW-1:0]  cr1_reg, ci1_reg;
    logic signed [32:0]     vr1_reg, vi1_reg;
    logic signed [50:0]     prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [31:0]     nr3_reg, ni3_reg;
    logic signed [31:0]     nr4_reg, ni4_reg;
    logic signed [63:0]     sqr4_reg, sqi4_reg;
    logic [63:0]            best_reg;
    logic [KW-1:0]          best_k_reg;
    logic                   out_valid_reg;
    dsdft_pkg::out_t        out_data_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign sts.adv  = adv;
    assign sts.busy = v0_reg || v1_reg || v2_reg || v3_reg;

    // Stage 1 arithmetic: damped coefficient and window-difference update.
    logic signed [35:0] pc_w, ps_w;
    logic signed [32:0] vr_w, vi_w;
    assign pc_w = $signed({1'b0, damping}) * twc0_reg + 36'sd32768;
    assign ps_w = $signed({1'b0, damping}) * tws0_reg + 36'sd32768;
    assign vr_w = $signed({re_q[31] & bvld_q, re_q & {32{bvld_q}}})
                + $signed({{7{diff_reg[25]}}, diff_reg});
    assign vi_w = $signed({im_q[31] & bvld_q, im_q & {32{bvld_q}}});

    // Stage 3 arithmetic: rounding and saturation.
    logic signed [51:0] sr_w, si_w;
    logic signed [35:0] qr_w, qi_w;
    logic signed [31:0] nr_w, ni_w;
    assign sr_w = $signed({prr_reg[50], prr_reg}) - $signed({pii_reg[50], pii_reg})
                + 52'sd32768;
    assign si_w = $signed({pri_reg[50], pri_reg}) + $signed({pir_reg[50], pir_reg})
                + 52'sd32768;
    assign qr_w = sr_w[51:16];
    assign qi_w = si_w[51:16];

    always_comb
    begin
        if (qr_w[35:31] == 5'b00000 || qr_w[35:31] == 5'b11111)
            nr_w = qr_w[31:0];
        else
            nr_w = qr_w[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        if (qi_w[35:31] == 5'b00000 || qi_w[35:31] == 5'b11111)
            ni_w = qi_w[31:0];
        else
            ni_w = qi_w[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    // Stage 5: magnitude and running peak.
    logic [63:0]   mag_w;
    logic          first_w;
    logic          better_w;
    logic [KW-1:0] peak_w;
    assign mag_w    = sqr4_reg + sqi4_reg;
    assign first_w  = (k4_reg == '0);
    assign better_w = first_w || (mag_w > best_reg);
    assign peak_w   = better_w ? k4_reg : best_k_reg;

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd)
            hist_q <= hist_mem[slot_in];
        if (cmd.make_diff)
            hist_mem[slot_in] <= x_reg;
        if (adv && cmd.issue)
        begin
            re_q <= re_mem[k_in];
            im_q <= im_mem[k_in];
        end
        if (adv && v3_reg)
        begin
            re_mem[k3_reg] <= nr3_reg;
            im_mem[k3_reg] <= ni3_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= x_ext;
        if (cmd.make_diff)
            diff_reg <= {delta[XW:0], 8'd0};
        if (adv)
        begin
            k0_reg   <= k_in;
            twc0_reg <= tw_tab[k_in][2*TWW-1:TWW];
            tws0_reg <= tw_tab[k_in][TWW-1:0];
            k1_reg   <= k0_reg;
            cr1_reg  <= pc_w[33:16];
            ci1_reg  <= ps_w[33:16];
            vr1_reg  <= vr_w;
            vi1_reg  <= vi_w;
            k2_reg   <= k1_reg;
            prr_reg  <= cr1_reg * vr1_reg;
            pii_reg  <= ci1_reg * vi1_reg;
            pri_reg  <= cr1_reg * vi1_reg;
            pir_reg  <= ci1_reg * vr1_reg;
            k3_reg   <= k2_reg;
            nr3_reg  <= nr_w;
            ni3_reg  <= ni_w;
            k4_reg   <= k3_reg;
            nr4_reg  <= nr3_reg;
            ni4_reg  <= ni3_reg;
            sqr4_reg <= nr3_reg * nr3_reg;
            sqi4_reg <= ni3_reg * ni3_reg;
            if (v4_reg)
            begin
                out_data_reg.bin_index  <= dsdft_pkg::IDX_W'(k4_reg);
                out_data_reg.bin_real   <= nr4_reg;
                out_data_reg.bin_imag   <= ni4_reg;
                out_data_reg.last_bin   <= (k4_reg == KW'(WINDOW - 1));
                out_data_reg.peak_index <= (k4_reg == KW'(WINDOW - 1))
                                         ? dsdft_pkg::IDX_W'(peak_w) : '0;
            end
            if (v4_reg && better_w)
            begin
                best_reg   <= mag_w;
                best_k_reg <= k4_reg;
            end
        end
    end

    // Control state: valid bits and pipeline occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg  <= '0;
            bin_vld_reg   <= '0;
            hist_vld_q    <= 1'b0;
            bvld_q        <= 1'b0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                hist_vld_reg <= '0;
                bin_vld_reg  <= '0;
            end
            if (cmd.hist_rd)
                hist_vld_q <= hist_vld_reg[slot_in];
            if (cmd.make_diff)
                hist_vld_reg[slot_in] <= 1'b1;
            if (adv)
            begin
                if (cmd.issue)
                    bvld_q <= bin_vld_reg[k_in];
                if (v3_reg)
                    bin_vld_reg[k3_reg] <= 1'b1;
                v0_reg        <= cmd.issue;
                v1_reg        <= v0_reg;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                out_valid_reg <= v4_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/damped_sliding_dft_peak_core.sv */
// Damped sliding DFT with peak search. A push request yields WINDOW bin results,
// one per cycle when unstalled, through the single shared complex multiply pipeline;
// a new request is not taken until the last bin write-back of the one before.
// A clear request yields no results, and the core stays ready for the next request.
// Reset clears the bins and history via valid bits at once, resets the slot, and sets damping to 1.0.
module damped_sliding_dft_peak_core #(
    parameter int WINDOW      = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dsdft_pkg::in_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dsdft_pkg::out_t               out_data,
    input  logic                          cfg_we,
    input  logic [dsdft_pkg::DAMP_W-1:0]  cfg_data
);

    dsdft_pkg::cmd_t                 cmd;
    dsdft_pkg::sts_t                 sts;
    logic [dsdft_pkg::DAMP_W-1:0]    damping_reg;

    // Values above unity act as unity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            damping_reg <= dsdft_pkg::DAMP_ONE;
        else if (cfg_we)
            damping_reg <= (cfg_data > dsdft_pkg::DAMP_ONE) ? dsdft_pkg::DAMP_ONE : cfg_data;
    end

    dsdft_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_op    (in_data.op),
        .sts      (sts),
        .cmd      (cmd)
    );

    dsdft_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .sample    (in_data.sample),
        .damping   (damping_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* tb/sv/dsdft_checker.sv */
// Checker for the damped sliding DFT core: watches both request channels, predicts bin results.
// Depends on dsdft_pkg for the payload types and the op codes.
`timescale 1ns / 1ps

module dsdft_checker #(
    parameter int WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  dsdft_pkg::in_t                in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  dsdft_pkg::out_t               out_data,
    input  logic                          cfg_we,
    input  logic [dsdft_pkg::DAMP_W-1:0]  cfg_data,
    output int                            fail_count,
    output int                            pending
);

    localparam longint ARC [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1
    };

    longint           rot_cos [WINDOW];
    longint           rot_sin [WINDOW];
    longint           spec_re [WINDOW];
    longint           spec_im [WINDOW];
    longint           history [WINDOW];
    int               oldest_slot;
    longint           gain;
    dsdft_pkg::out_t  bins_due [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Rotation factors for each bin, in Q16, from a folded integer CORDIC.
    task automatic build_rotations();
        logic [31:0] ph;
        logic        neg;
        longint      cx;
        longint      cy;
        longint      ang;
        longint      sx;
        longint      sy;
        for (int k = 0; k < WINDOW; k++)
        begin
            ph = 32'((64'(k) << 32) / WINDOW);
            neg = 1'b0;
            if (ph >= 32'h4000_0000 && ph < 32'hC000_0000)
            begin
                ph = ph - 32'h8000_0000;
                neg = 1'b1;
            end
            ang = longint'($signed(ph));
            cx = 652032874;
            cy = 0;
            for (int i = 0; i < 30; i++)
            begin
                sx = cy >>> i;
                sy = cx >>> i;
                if (ang >= 0)
                begin
                    cx -= sx;
                    cy += sy;
                    ang -= ARC[i];
                end
                else
                begin
                    cx += sx;
                    cy -= sy;
                    ang += ARC[i];
                end
            end
            if (neg)
            begin
                cx = -cx;
                cy = -cy;
            end
            rot_cos[k] = (cx + 8192) >>> 14;
            rot_sin[k] = (cy + 8192) >>> 14;
        end
    endtask

    task automatic wipe_window();
        for (int k = 0; k < WINDOW; k++)
        begin
            spec_re[k] = 0;
            spec_im[k] = 0;
            history[k] = 0;
        end
        oldest_slot = 0;
    endtask

    task automatic slide_sample(input logic [15:0] raw);
        longint          delta;
        longint          cr;
        longint          ci;
        longint          vr;
        longint          vi;
        longint          nr;
        longint          ni;
        longint unsigned power;
        longint unsigned top_power;
        int              top_bin;
        dsdft_pkg::out_t r;
        top_power = 0;
        top_bin = 0;
        delta = (longint'($signed(raw)) - history[oldest_slot]) * 256;
        for (int k = 0; k < WINDOW; k++)
        begin
            cr = (gain * rot_cos[k] + 32768) >>> 16;
            ci = (gain * rot_sin[k] + 32768) >>> 16;
            vr = spec_re[k] + delta;
            vi = spec_im[k];
            nr = clamp32((cr * vr - ci * vi + 32768) >>> 16);
            ni = clamp32((cr * vi + ci * vr + 32768) >>> 16);
            spec_re[k] = nr;
            spec_im[k] = ni;
            power = longint'(nr * nr) + longint'(ni * ni);
            if (power > top_power)
            begin
                top_power = power;
                top_bin = k;
            end
            r.bin_index = dsdft_pkg::IDX_W'(k);
            r.bin_real = nr[31:0];
            r.bin_imag = ni[31:0];
            r.last_bin = (k == WINDOW - 1);
            r.peak_index = (k == WINDOW - 1) ? dsdft_pkg::IDX_W'(top_bin) : '0;
            bins_due.push_back(r);
        end
        history[oldest_slot] = longint'($signed(raw));
        oldest_slot = (oldest_slot + 1) % WINDOW;
    endtask

    initial
    begin
        build_rotations();
    end

    always @(posedge clk)
    begin
        dsdft_pkg::out_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            gain = 65536;
            bins_due.delete();
            wipe_window();
        end
        else
        begin
            if (cfg_we)
            begin
                gain = (cfg_data > dsdft_pkg::DAMP_ONE) ? 65536 : longint'(cfg_data);
            end
            if (out_valid && out_ready)
            begin
                if (bins_due.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = bins_due.pop_front();
                    if (want !== out_data)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.op == dsdft_pkg::OP_CLEAR)
                begin
                    wipe_window();
                end
                else
                begin
                    slide_sample(in_data.sample);
                end
            end
        end
        pending = bins_due.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the damped sliding DFT testbench: clock, reset, requests, damping writes and verdict.
// Depends on dsdft_pkg, the core and dsdft_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 5000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    dsdft_pkg::in_t                in_data;
    logic                          out_valid;
    logic                          out_ready;
    dsdft_pkg::out_t               out_data;
    logic                          cfg_we;
    logic [dsdft_pkg::DAMP_W-1:0]  cfg_data;
    int                            fail_count;
    int                            pending;
    logic                          calm;
    logic                          hold_req;
    int                            quiet_cycles;

    damped_sliding_dft_peak_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    dsdft_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready = 1'b0;
                for (int n = 0; n < 400; n++)
                begin
                    @(negedge clk);
                end
                hold_done = 1'b1;
                out_ready = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) < 2)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send(input logic op, input logic [15:0] smp);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.op = op;
        in_data.sample = smp;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    // Damping writes happen only once every bin result is out and the core has settled.
    task automatic set_damping(input logic [dsdft_pkg::DAMP_W-1:0] v);
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [dsdft_pkg::DAMP_W-1:0] damp_set [6];
        damp_set = '{17'd65535, 17'd0, 17'd131071, 17'd65537, 17'd60000, 17'd65536};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes at full damping, a clear mid-stream, a clear on empty state.
        send(dsdft_pkg::OP_PUSH, 16'h7FFF);
        send(dsdft_pkg::OP_PUSH, 16'h8000);
        send(dsdft_pkg::OP_PUSH, 16'h0000);
        send(dsdft_pkg::OP_PUSH, 16'hFFFF);
        send(dsdft_pkg::OP_PUSH, 16'h0001);
        send(dsdft_pkg::OP_CLEAR, 16'hFFFF);
        send(dsdft_pkg::OP_CLEAR, 16'h0000);
        for (int i = 0; i < 6; i++)
        begin
            send(dsdft_pkg::OP_PUSH, (i % 2) ? 16'h8000 : 16'h7FFF);
        end
        set_damping(17'd0);
        send(dsdft_pkg::OP_PUSH, 16'h1234);
        send(dsdft_pkg::OP_PUSH, 16'h8000);
        set_damping(17'd131071);
        send(dsdft_pkg::OP_PUSH, 16'h7FFF);
        send(dsdft_pkg::OP_PUSH, 16'h5555);
        send(dsdft_pkg::OP_PUSH, 16'hAAAA);
        send(dsdft_pkg::OP_CLEAR, 16'h0000);

        // Random phases, each with its own damping; the long hold-off lands in phase one.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_damping(ph == 5 ? dsdft_pkg::DAMP_W'($urandom_range(0, 131071))
                                : damp_set[ph]);
            if (ph == 5)
            begin
                calm = 1'b1;
            end
            for (int i = 0; i < 60; i++)
            begin
                if (ph == 1 && i == 5)
                begin
                    hold_req = 1'b1;
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    send(dsdft_pkg::OP_CLEAR, 16'($urandom));
                end
                else
                begin
                    send(dsdft_pkg::OP_PUSH, pick_sample());
                end
            end
        end

        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
